### design/lcdseq_pkg.sv
// shared types, codes and item generation for the character lcd nibble sequencer
package lcdseq_pkg;

   // request codes
   typedef enum logic [2:0] {
      OP_INIT      = 3'd0,
      OP_COMMAND   = 3'd1,
      OP_CHAR      = 3'd2,
      OP_CURSOR    = 3'd3,
      OP_CLEAR     = 3'd4,
      OP_SHIFT_L   = 3'd5,
      OP_SHIFT_R   = 3'd6,
      OP_RESERVED  = 3'd7
   } op_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_ENABLE_PULSE = 1'b0,
      CSR_CHAR_WAIT    = 1'b1
   } csr_index_type;

   // controller states
   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   localparam int StepW = 4;
   localparam int LenW  = 5;

   localparam logic [15:0] ENABLE_PULSE_RESET = 16'd5000;
   localparam logic [15:0] CHAR_WAIT_RESET    = 16'd40;

   localparam logic [13:0] WAIT_POWER_ON_US = 14'd16000;
   localparam logic [15:0] WAIT_INIT1_US    = 16'd5000;
   localparam logic [15:0] WAIT_INIT2_US    = 16'd110;
   localparam logic [15:0] WAIT_CMD_US      = 16'd40;
   localparam logic [15:0] WAIT_HOME_US     = 16'd2000;
   localparam logic [15:0] WAIT_CURSOR_US   = 16'd2040;

   localparam logic [7:0] CURSOR_ROW1_BASE = 8'h80;
   localparam logic [7:0] CURSOR_ROW2_BASE = 8'hC0;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON7  = 8'h07;
   localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h18;
   localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h1C;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_HOME         = 8'h02;

   // nibbles of the power-on sequence, in order
   localparam logic [3:0] INIT_NIBBLES [16] = '{
      4'h3, 4'h3, 4'h3, 4'h2,
      4'h2, 4'hC, 4'h0, 4'h8,
      4'h0, 4'h1, 4'h0, 4'hE,
      4'h0, 4'h6, 4'h0, 4'h2
   };

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] value;
      logic [1:0] row;
      logic [4:0] column;
   } req_type;

   typedef struct packed {
      logic        strobe_res;
      logic        reg_select;
      logic [3:0]  nibble;
      logic [15:0] pulse_us;
      logic [13:0] wait_before_us;
      logic [15:0] wait_after_us;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic             load_req;
      logic             load_rsp;
      logic [StepW-1:0] step;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic last_step;
      logic empty_run;
   } ctl_sts_type;

   function automatic logic cursor_row_ok(input logic [1:0] row);
      return (row == 2'd1) || (row == 2'd2);
   endfunction

   // number of items a request produces
   function automatic logic [LenW-1:0] run_len(input req_type r);
      logic [LenW-1:0] len;
      unique case (op_type'(r.op))
         OP_INIT:    len = 5'd16;
         OP_COMMAND: len = 5'd2;
         OP_CHAR:    len = 5'd2;
         OP_CURSOR:  len = cursor_row_ok(r.row) ? 5'd2 : 5'd1;
         OP_CLEAR:   len = 5'd4;
         OP_SHIFT_L: len = 5'd6;
         OP_SHIFT_R: len = 5'd6;
         default:    len = 5'd0;
      endcase
      return len;
   endfunction

   // one item of a run, selected by step
   function automatic rsp_type make_item(input req_type r, input logic [StepW-1:0] step,
                                         input logic [15:0] pulse,
                                         input logic [15:0] char_wait);
      rsp_type         it;
      logic [7:0]      byte_v;
      logic [7:0]      mid;
      logic [LenW-1:0] len;
      it     = '0;
      byte_v = 8'h00;
      mid    = (op_type'(r.op) == OP_SHIFT_R) ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
      len    = run_len(r);
      it.strobe_res = 1'b1;
      unique case (op_type'(r.op))
         OP_INIT: begin
            it.nibble = INIT_NIBBLES[step];
            if (step == 4'd0) begin
               it.wait_before_us = WAIT_POWER_ON_US;
               it.wait_after_us  = WAIT_INIT1_US;
            end else if (step == 4'd1) begin
               it.wait_after_us = WAIT_INIT2_US;
            end else if (step == 4'd15) begin
               it.wait_after_us = WAIT_HOME_US;
            end
         end
         OP_COMMAND: begin
            byte_v = r.value;
         end
         OP_CHAR: begin
            byte_v        = r.value;
            it.reg_select = 1'b1;
            if (step[0]) begin
               it.wait_after_us = char_wait;
            end
         end
         OP_CURSOR: begin
            if (cursor_row_ok(r.row)) begin
               byte_v = ((r.row == 2'd1) ? CURSOR_ROW1_BASE : CURSOR_ROW2_BASE)
                        + {3'b000, r.column} - 8'd1;
               if (step[0]) begin
                  it.wait_after_us = WAIT_CURSOR_US;
               end
            end else begin
               it.strobe_res    = 1'b0;
               it.wait_after_us = WAIT_HOME_US;
            end
         end
         OP_CLEAR: begin
            byte_v = step[1] ? CMD_HOME : CMD_CLEAR;
            if (step[1] && step[0]) begin
               it.wait_after_us = WAIT_HOME_US;
            end
         end
         OP_SHIFT_L, OP_SHIFT_R: begin
            unique case (step[2:1])
               2'd0:    byte_v = CMD_DISPLAY_ON7;
               2'd1:    byte_v = mid;
               default: byte_v = CMD_ENTRY_MODE;
            endcase
            if (step[0]) begin
               it.wait_after_us = WAIT_CMD_US;
            end
         end
         default: begin
            it.strobe_res = 1'b0;
         end
      endcase
      // byte requests: high nibble on even steps, low nibble on odd steps
      if (op_type'(r.op) != OP_INIT && it.strobe_res) begin
         it.nibble = step[0] ? byte_v[3:0] : byte_v[7:4];
      end
      it.pulse_us = it.strobe_res ? pulse : 16'd0;
      it.last     = ({1'b0, step} == (len - 5'd1));
      return it;
   endfunction

endpackage

### design/char_lcd_nibble_sequencer.sv
// top level of the character lcd 4-bit nibble sequencer
//
// req channel: one beat is a request (init, command, char, set cursor,
// clear, shift left, shift right). rsp channel: a run of 1 to 16 beats,
// each a nibble transfer with enable pulse or a bare wait, last set on
// the final beat of the run. Reserved op code 7 is accepted and yields
// no beat.
// csr port: csr_we writes csr_wdata into register csr_index (0 enable
// pulse width, 1 char wait); write it only while no run is in progress.
// An accepted req beat is latched into the request register as the
// controller enters its run state; its first item is then loaded
// into the output register once free. Throughput: one rsp beat per
// cycle during a run while rsp_stall is low; req_stall stays high while
// the controller runs, until the last item is loaded (op 7 loads none).
// A stalled rsp beat holds its payload and pauses the run; the next
// request is accepted once the last beat of the run sits in the output
// register, even if it is still stalled.
// Reset clears the controller and output valid and restores the
// config registers to 5000 us pulse and 40 us char wait.
module char_lcd_nibble_sequencer
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencing control
   lcdseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // item datapath
   lcdseq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### design/lcdseq_ctrl.sv
// run controller: accepts a request and steps through its items
module lcdseq_ctrl
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;

   // state and step registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.load_req = 1'b0;
      cmd.load_rsp = 1'b0;
      cmd.step     = step_ff;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               step_in      = '0;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.empty_run) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               if (sts.last_step) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/lcdseq_dp.sv
// datapath: config registers, request latch, item generation and output register
module lcdseq_dp
   import lcdseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  ctl_cmd_type cmd,
   output ctl_sts_type sts
);

   logic [15:0] pulse_ff, char_wait_ff;
   req_type     req_ff;
   rsp_type     rsp_ff, item;
   logic        valid_ff, valid_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff     <= ENABLE_PULSE_RESET;
         char_wait_ff <= CHAR_WAIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE_PULSE: pulse_ff     <= csr_wdata;
            CSR_CHAR_WAIT:    char_wait_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   // item for the current step
   always_comb begin
      item = make_item(req_ff, cmd.step, pulse_ff, char_wait_ff);
   end

   // output register, one beat held until taken
   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_rsp) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= item;
      end
   end

   // status back to the controller
   assign sts.out_free  = !valid_ff || !rsp_stall;
   assign sts.last_step = item.last;
   assign sts.empty_run = (run_len(req_ff) == 5'd0);

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### dv/testbench.sv
// self-checking testbench for the character lcd nibble sequencer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lcdseq_pkg::*;

   // command bytes and waits of the lcd protocol, kept apart from the design package
   localparam logic [7:0]  BYTE_FUNCTION_SET = 8'h2C;
   localparam logic [7:0]  BYTE_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0]  BYTE_CLEAR        = 8'h01;
   localparam logic [7:0]  BYTE_DISPLAY_ON   = 8'h0E;
   localparam logic [7:0]  BYTE_ENTRY_MODE   = 8'h06;
   localparam logic [7:0]  BYTE_HOME         = 8'h02;
   localparam logic [7:0]  BYTE_SHIFT_PREP   = 8'h07;
   localparam logic [7:0]  BYTE_SHIFT_LEFT   = 8'h18;
   localparam logic [7:0]  BYTE_SHIFT_RIGHT  = 8'h1C;
   localparam logic [7:0]  BYTE_ROW1         = 8'h80;
   localparam logic [7:0]  BYTE_ROW2         = 8'hC0;
   localparam logic [3:0]  NIB_WAKE          = 4'h3;
   localparam logic [3:0]  NIB_FOUR_BIT      = 4'h2;
   localparam logic [13:0] US_POWER_ON       = 14'd16000;
   localparam logic [15:0] US_WAKE1          = 16'd5000;
   localparam logic [15:0] US_WAKE2          = 16'd110;
   localparam logic [15:0] US_CMD            = 16'd40;
   localparam logic [15:0] US_HOME           = 16'd2000;
   localparam logic [15:0] PULSE_AT_RESET    = 16'd5000;
   localparam logic [15:0] CHAR_WAIT_AT_RESET = 16'd40;

   localparam int IDLE_LIMIT      = 3000;
   localparam int TAIL_CYCLES     = 8;
   localparam int CSR_SETTLE      = 4;
   localparam int HOLD_CYCLES     = 150;
   localparam int HOLD_BURST      = 14;
   localparam int N_PHASES        = 6;
   localparam int ITEMS_PER_PHASE = 48;

   // expected transfers per request, and the check of every rsp beat
   class transfer_ledger;
      logic [15:0] pulse_us;
      logic [15:0] char_wait_us;
      rsp_type     awaited[$];
      int          requests_by_op[8];
      int          transfers_checked;
      int          mismatches;

      function new();
         pulse_us          = PULSE_AT_RESET;
         char_wait_us      = CHAR_WAIT_AT_RESET;
         transfers_checked = 0;
         mismatches        = 0;
         foreach (requests_by_op[i]) requests_by_op[i] = 0;
      endfunction

      // one nibble transfer, or a bare wait when strobe is low
      function void push_transfer(bit strobe, bit rs, logic [3:0] nib,
                                  logic [13:0] lead_us, logic [15:0] tail_us);
         rsp_type t;
         t                = '0;
         t.strobe_res     = strobe;
         t.reg_select     = rs;
         t.nibble         = nib;
         t.pulse_us       = strobe ? pulse_us : 16'd0;
         t.wait_before_us = lead_us;
         t.wait_after_us  = tail_us;
         t.last           = 1'b0;
         awaited.push_back(t);
      endfunction

      // high nibble first; only the low nibble carries the trailing wait
      function void push_byte(bit rs, logic [7:0] b, logic [15:0] tail_us);
         push_transfer(1'b1, rs, b[7:4], 14'd0, 16'd0);
         push_transfer(1'b1, rs, b[3:0], 14'd0, tail_us);
      endfunction

      function void push_shift(logic [7:0] mid);
         push_byte(1'b0, BYTE_SHIFT_PREP, US_CMD);
         push_byte(1'b0, mid, US_CMD);
         push_byte(1'b0, BYTE_ENTRY_MODE, US_CMD);
      endfunction

      // accepted req beat: append its whole run, flag the final item
      function void expand_request(req_type r);
         int         start_size;
         rsp_type    t;
         logic [7:0] cursor_byte;
         start_size = awaited.size();
         requests_by_op[r.op]++;
         case (op_type'(r.op))
            OP_INIT: begin
               push_transfer(1'b1, 1'b0, NIB_WAKE, US_POWER_ON, US_WAKE1);
               push_transfer(1'b1, 1'b0, NIB_WAKE, 14'd0, US_WAKE2);
               push_transfer(1'b1, 1'b0, NIB_WAKE, 14'd0, 16'd0);
               push_transfer(1'b1, 1'b0, NIB_FOUR_BIT, 14'd0, 16'd0);
               push_byte(1'b0, BYTE_FUNCTION_SET, 16'd0);
               push_byte(1'b0, BYTE_DISPLAY_OFF, 16'd0);
               push_byte(1'b0, BYTE_CLEAR, 16'd0);
               push_byte(1'b0, BYTE_DISPLAY_ON, 16'd0);
               push_byte(1'b0, BYTE_ENTRY_MODE, 16'd0);
               push_byte(1'b0, BYTE_HOME, US_HOME);
            end
            OP_COMMAND: push_byte(1'b0, r.value, 16'd0);
            OP_CHAR:    push_byte(1'b1, r.value, char_wait_us);
            OP_CURSOR: begin
               // rows other than 1 and 2 only wait; column wraps modulo 256
               if (r.row == 2'd1 || r.row == 2'd2) begin
                  cursor_byte = ((r.row == 2'd1) ? BYTE_ROW1 : BYTE_ROW2)
                                + {3'b000, r.column} - 8'd1;
                  push_byte(1'b0, cursor_byte, US_CMD + US_HOME);
               end else begin
                  push_transfer(1'b0, 1'b0, 4'h0, 14'd0, US_HOME);
               end
            end
            OP_CLEAR: begin
               push_byte(1'b0, BYTE_CLEAR, 16'd0);
               push_byte(1'b0, BYTE_HOME, US_HOME);
            end
            OP_SHIFT_L: push_shift(BYTE_SHIFT_LEFT);
            OP_SHIFT_R: push_shift(BYTE_SHIFT_RIGHT);
            default: ;
         endcase
         if (awaited.size() > start_size) begin
            t      = awaited.pop_back();
            t.last = 1'b1;
            awaited.push_back(t);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report_mismatch($sformatf("beat %0d %s got %0d expected %0d",
                                      transfers_checked, name, got, want));
      endtask

      // accepted rsp beat against the oldest expectation
      task check_transfer(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                      transfers_checked));
            transfers_checked++;
         end else begin
            want = awaited.pop_front();
            compare_field("strobe_res", got.strobe_res, want.strobe_res);
            compare_field("reg_select", got.reg_select, want.reg_select);
            compare_field("nibble", got.nibble, want.nibble);
            compare_field("pulse_us", got.pulse_us, want.pulse_us);
            compare_field("wait_before_us", got.wait_before_us, want.wait_before_us);
            compare_field("wait_after_us", got.wait_after_us, want.wait_after_us);
            compare_field("last", got.last, want.last);
            transfers_checked++;
         end
      endtask

      task report_leftovers();
         if (awaited.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", awaited.size()));
      endtask
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_we    = 1'b0;
   logic [0:0]  csr_index = CSR_ENABLE_PULSE;
   logic [15:0] csr_wdata = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;

   transfer_ledger ledger = new();

   int hold_ticket   = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int segment_left  = 0;
   bit segment_stall = 1'b0;
   int idle_cycles   = 0;
   int counted_items = 0;
   int settings_used = 1;

   char_lcd_nibble_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ledger.expand_request(req_data);
         if (rsp_valid && !rsp_stall) ledger.check_transfer(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   // receiver: random stall segments, plus a long hold when asked
   always @(posedge clock) begin
      int pick;
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (segment_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               segment_stall = 1'b0;
               segment_left  = $urandom_range(4, 40);
            end else if (pick < 85) begin
               segment_stall = 1'b1;
               segment_left  = $urandom_range(1, 3);
            end else if (pick < 95) begin
               segment_stall = 1'b0;
               segment_left  = $urandom_range(1, 3);
            end else begin
               segment_stall = 1'b1;
               segment_left  = $urandom_range(10, 40);
            end
         end
         segment_left--;
         rsp_stall <= segment_stall;
      end
   end

   // offer one req beat and hold it until accepted
   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op_type'(r.op) != OP_RESERVED) counted_items++;
   endtask

   task automatic sender_gap(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // mostly back to back or short gaps, a few long ones
   function automatic int pick_gap(bit eager);
      int pick;
      pick = $urandom_range(0, 99);
      if (eager || pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // stop offering until every expected beat is back, then let a reserved op settle
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
   endtask

   // write both registers back to back; only called while idle
   task automatic set_config(logic [15:0] pulse, logic [15:0] char_wait);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENABLE_PULSE;
      csr_wdata <= pulse;
      @(posedge clock);
      csr_index <= CSR_CHAR_WAIT;
      csr_wdata <= char_wait;
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.pulse_us     = pulse;
      ledger.char_wait_us = char_wait;
      settings_used++;
   endtask

   function automatic req_type make_req(op_type op, logic [7:0] value, logic [1:0] row,
                                        logic [4:0] column);
      req_type r;
      r.op     = op;
      r.value  = value;
      r.row    = row;
      r.column = column;
      return r;
   endfunction

   // mostly chars, commands and in-range cursors; ignored fields stay random
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)       r.op = OP_INIT;
      else if (pick < 24) r.op = OP_COMMAND;
      else if (pick < 54) r.op = OP_CHAR;
      else if (pick < 74) r.op = OP_CURSOR;
      else if (pick < 81) r.op = OP_CLEAR;
      else if (pick < 88) r.op = OP_SHIFT_L;
      else if (pick < 95) r.op = OP_SHIFT_R;
      else                r.op = OP_RESERVED;
      r.value = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) r.row = $urandom_range(0, 1) ? 2'd3 : 2'd0;
      else                           r.row = 2'($urandom_range(1, 2));
      if ($urandom_range(0, 6) == 0) r.column = 5'($urandom_range(0, 31));
      else                           r.column = 5'($urandom_range(1, 16));
      return r;
   endfunction

   // stimulus
   initial begin
      req_type directed[$];
      int      phase;
      int      target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every op, field extremes, odd rows, wrapping columns
      directed.push_back(make_req(OP_INIT, 8'h00, 2'd0, 5'd0));
      directed.push_back(make_req(OP_COMMAND, 8'h00, 2'd0, 5'd0));
      directed.push_back(make_req(OP_COMMAND, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(OP_CHAR, 8'h00, 2'd1, 5'd1));
      directed.push_back(make_req(OP_CHAR, 8'hFF, 2'd2, 5'd16));
      directed.push_back(make_req(OP_CHAR, 8'h5A, 2'd0, 5'd0));
      directed.push_back(make_req(OP_CURSOR, 8'h00, 2'd1, 5'd1));
      directed.push_back(make_req(OP_CURSOR, 8'hFF, 2'd1, 5'd16));
      directed.push_back(make_req(OP_CURSOR, 8'h00, 2'd2, 5'd1));
      directed.push_back(make_req(OP_CURSOR, 8'h00, 2'd2, 5'd16));
      directed.push_back(make_req(OP_CURSOR, 8'h00, 2'd1, 5'd0));
      directed.push_back(make_req(OP_CURSOR, 8'h00, 2'd2, 5'd31));
      directed.push_back(make_req(OP_CURSOR, 8'h00, 2'd0, 5'd5));
      directed.push_back(make_req(OP_CURSOR, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(OP_CLEAR, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(OP_SHIFT_L, 8'h00, 2'd0, 5'd0));
      directed.push_back(make_req(OP_SHIFT_R, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(OP_RESERVED, 8'hFF, 2'd3, 5'd31));
      directed.push_back(make_req(OP_COMMAND, 8'hA5, 2'd1, 5'd10));
      directed.push_back(make_req(OP_INIT, 8'hFF, 2'd3, 5'd31));
      foreach (directed[i]) begin
         send_request(directed[i]);
         sender_gap(pick_gap(1'b0));
      end
      pause_until_drained();

      // random phases, each under its own register setting
      for (phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0:       set_config(16'd1, 16'd0);
            1:       set_config(16'hFFFF, 16'hFFFF);
            4:       set_config(PULSE_AT_RESET, CHAR_WAIT_AT_RESET);
            default: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
         endcase
         target = counted_items + ITEMS_PER_PHASE;
         // receiver holds off while the sender keeps offering back to back
         if (phase == 2) begin
            hold_ticket <= hold_ticket + 1;
            repeat (HOLD_BURST) send_request(random_request());
         end
         while (counted_items < target) begin
            send_request(random_request());
            if (phase == 3 && counted_items == target - ITEMS_PER_PHASE / 2)
               pause_until_drained();
            else
               sender_gap(pick_gap(phase == 1));
         end
         pause_until_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      ledger.report_leftovers();
      $display("ops: init %0d cmd %0d char %0d cursor %0d clear %0d shift %0d rsvd %0d",
               ledger.requests_by_op[OP_INIT], ledger.requests_by_op[OP_COMMAND],
               ledger.requests_by_op[OP_CHAR], ledger.requests_by_op[OP_CURSOR],
               ledger.requests_by_op[OP_CLEAR],
               ledger.requests_by_op[OP_SHIFT_L] + ledger.requests_by_op[OP_SHIFT_R],
               ledger.requests_by_op[OP_RESERVED]);
      $display("%0d rsp beats checked under %0d register settings, %0d mismatches",
               ledger.transfers_checked, settings_used, ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
